@@ design/rk4_spring_mass_damper_step_top_defines.svh @@
// ----------------------------------------------------------------------------
// RK4 spring-mass-damper step: assertion macros
// Shared macros for the concurrent assertions of the step block checker.
// ----------------------------------------------------------------------------
`ifndef RK4_SPRING_MASS_DAMPER_STEP_TOP_DEFINES_SVH
`define RK4_SPRING_MASS_DAMPER_STEP_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define RK4_ASSERT_IMP(label, clk, dis, pre, post) \
   label: assert property (@(posedge clk) disable iff (dis) (pre) |-> (post)) \
      else $error("rk4 step: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define RK4_ASSERT_NEXT(label, clk, dis, pre, post) \
   label: assert property (@(posedge clk) disable iff (dis) (pre) |=> (post)) \
      else $error("rk4 step: next-cycle check failed");

`endif

@@ design/rk4_smd_pkg.sv @@
// ----------------------------------------------------------------------------
// RK4 spring-mass-damper step: package
// Widths, register codes, reset values and arithmetic helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rk4_smd_pkg;

   localparam int DATA_W        = 32;
   localparam int UREG_W        = 31;
   localparam int AXIS_W        = 2;
   localparam int CSR_IDX_W     = 3;
   localparam int FRAC_BITS_DEF = 16;
   localparam int AXES          = 3;
   localparam int GRAVITY_REGS  = 3;
   localparam int PROD_W        = 64;
   localparam int SHIFT_W       = 6;

   // Weighted stage sum k1 + 2*k2 + 2*k3 + k4 of 32-bit values.
   localparam int SUM_W         = 35;

   // Floor division by six is done as a long division in 9-bit digits.
   localparam int STAGE_DIVISOR = 6;
   localparam int DIV_W         = 36;
   localparam int DIV_CHUNK     = 9;
   localparam int DIV_REM_W     = 3;
   localparam int DIV_CUR_W     = DIV_REM_W + DIV_CHUNK;
   localparam int DIV6_RECIP    = 2731;
   localparam int DIV6_SHIFT    = 14;
   localparam int DIV_PROD_W    = 2 * DIV_CUR_W + 2;

   // Rounding offset plus a bias of six times 2^32 that keeps the dividend positive.
   localparam logic signed [DIV_W:0] DIV_BIAS =
      (DIV_W + 1)'(STAGE_DIVISOR / 2) + ((DIV_W + 1)'(STAGE_DIVISOR) <<< DATA_W);

   localparam logic signed [DATA_W-1:0] STIFF_RESET = 32'sd65536;
   localparam logic signed [DATA_W-1:0] DAMP_RESET  = 32'sd0;
   localparam logic [UREG_W-1:0]        IMASS_RESET = 31'd65536;
   localparam logic [UREG_W-1:0]        STEP_RESET  = 31'd6554;
   localparam logic signed [DATA_W-1:0] GRAV_RESET  = 32'sd0;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STIFFNESS = 3'd0,
      CSR_DAMPING   = 3'd1,
      CSR_INV_MASS  = 3'd2,
      CSR_STEP      = 3'd3,
      CSR_GRAV_X    = 3'd4,
      CSR_GRAV_Y    = 3'd5,
      CSR_GRAV_Z    = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] val;
      logic                     sat;
   } clip_type;

   typedef struct packed {
      logic [DIV_CHUNK-1:0] q;
      logic [DIV_REM_W-1:0] r;
   } div_step_type;

   // Scale a product by 2^-s, rounding to nearest with ties toward plus infinity.
   function automatic logic signed [PROD_W-1:0] round_shift(
      input logic signed [PROD_W-1:0] p,
      input logic [SHIFT_W-1:0]       s
   );
      logic signed [PROD_W-1:0] half;
      half = 64'sd1 <<< (s - 6'd1);
      return (p + half) >>> s;
   endfunction

   function automatic clip_type clip32(input logic signed [PROD_W-1:0] v);
      clip_type res;
      if (v > 64'sd2147483647) begin
         res.val = 32'sh7fffffff;
         res.sat = 1'b1;
      end else if (v < -64'sd2147483648) begin
         res.val = 32'sh80000000;
         res.sat = 1'b1;
      end else begin
         res.val = v[DATA_W-1:0];
         res.sat = 1'b0;
      end
      return res;
   endfunction

   // One digit of the long division: the partial remainder is below six, so the
   // working value stays under 3072 and the reciprocal multiply is exact.
   function automatic div_step_type div6_step(
      input logic [DIV_REM_W-1:0] r_in,
      input logic [DIV_CHUNK-1:0] chunk
   );
      logic [DIV_CUR_W-1:0]  cur;
      logic [DIV_PROD_W-1:0] prod;
      logic [DIV_CUR_W-1:0]  back;
      div_step_type          res;
      cur   = {r_in, chunk};
      prod  = DIV_PROD_W'(cur) * DIV_PROD_W'(DIV6_RECIP);
      res.q = prod[DIV6_SHIFT +: DIV_CHUNK];
      back  = cur - DIV_CUR_W'(res.q) * DIV_CUR_W'(STAGE_DIVISOR);
      res.r = back[DIV_REM_W-1:0];
      return res;
   endfunction

endpackage

@@ design/rk4_spring_mass_damper_step_top.sv @@
// ----------------------------------------------------------------------------
// RK4 spring-mass-damper step
// Advances one axis of a damped mass-spring system by one fourth-order
// Runge-Kutta step in signed fixed point, as a fully pipelined datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// The block takes one item per clock cycle while the output is not stalled
// (axis, position, velocity, external force) and returns next position, next
// velocity and a saturation flag for every item, in order. Each item passes
// through four chained evaluations of the acceleration, each a multiply stage,
// two add stages and (for the first three) a step-size multiply and an update
// stage, then a weighted sum, a two-stage divide by six and a final multiply
// and update. Every stage holds its own valid bit and moves on when the stage
// after it is empty or moving, so bubbles close up and input is still taken
// while a finished result waits at the output register. The constants k/m,
// c/m, 1/m, h and the gravity values come from the csr_ port; they must only
// be written while no item is in flight. Every clip of a stage value or a
// result to the 32-bit range raises rsp_saturated for that item.
module rk4_spring_mass_damper_step_top #(
   parameter int FRAC_BITS = rk4_smd_pkg::FRAC_BITS_DEF
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_ready,
   input  logic [rk4_smd_pkg::AXIS_W-1:0]              req_axis_index,
   input  logic signed [rk4_smd_pkg::DATA_W-1:0]       req_position,
   input  logic signed [rk4_smd_pkg::DATA_W-1:0]       req_velocity,
   input  logic signed [rk4_smd_pkg::DATA_W-1:0]       req_external_force,
   output logic                                        rsp_valid,
   input  logic                                        rsp_ready,
   output logic signed [rk4_smd_pkg::DATA_W-1:0]       rsp_next_position,
   output logic signed [rk4_smd_pkg::DATA_W-1:0]       rsp_next_velocity,
   output logic                                        rsp_saturated,
   input  logic                                        csr_valid,
   output logic                                        csr_ready,
   input  logic [rk4_smd_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [rk4_smd_pkg::DATA_W-1:0]              csr_wdata
);

   // Width of a product scaled by 2^-FRAC_BITS, and of the sums built from it.
   localparam int RW  = rk4_smd_pkg::PROD_W - FRAC_BITS;
   localparam int FGW = RW + 1;
   localparam int NSW = RW + 2;
   localparam int AW  = RW + 3;
   localparam int UW  = RW + 1;

   localparam logic [rk4_smd_pkg::SHIFT_W-1:0] SHIFT_FULL =
      rk4_smd_pkg::SHIFT_W'(FRAC_BITS);
   localparam logic [rk4_smd_pkg::SHIFT_W-1:0] SHIFT_HALF =
      rk4_smd_pkg::SHIFT_W'(FRAC_BITS + 1);

   // Stage map: each Runge-Kutta evaluation uses five stages (multiply,
   // negated sum, acceleration, step multiply, update); the last one stops
   // after the acceleration and hands over to the final section.
   localparam int RK_STAGES   = 4;
   localparam int STG_PER_RK  = 5;
   localparam int STG_SUM     = (RK_STAGES - 1) * STG_PER_RK + 3;
   localparam int STG_DIV     = STG_SUM + 1;
   localparam int DIV_STAGES  = 2;
   localparam int STG_HMUL    = STG_DIV + DIV_STAGES;
   localparam int STG_OUT     = STG_HMUL + 1;
   localparam int NSTG        = STG_OUT + 1;
   localparam int DIV_PER_STG = rk4_smd_pkg::DIV_W / rk4_smd_pkg::DIV_CHUNK / DIV_STAGES;

   typedef struct packed {
      logic signed [rk4_smd_pkg::DATA_W-1:0] x;
      logic signed [rk4_smd_pkg::DATA_W-1:0] v;
      logic signed [rk4_smd_pkg::DATA_W-1:0] g;
      logic signed [rk4_smd_pkg::DATA_W-1:0] xs;
      logic signed [rk4_smd_pkg::DATA_W-1:0] vs;
      logic signed [rk4_smd_pkg::DATA_W-1:0] kv;
      logic signed [rk4_smd_pkg::PROD_W-1:0] pa;
      logic signed [rk4_smd_pkg::PROD_W-1:0] pb;
      logic signed [rk4_smd_pkg::PROD_W-1:0] pc;
      logic signed [FGW-1:0]                 fg;
      logic signed [NSW-1:0]                 ns;
      logic signed [rk4_smd_pkg::SUM_W-1:0]  sx;
      logic signed [rk4_smd_pkg::SUM_W-1:0]  sv;
      logic [rk4_smd_pkg::DIV_W-1:0]         mx;
      logic [rk4_smd_pkg::DIV_W-1:0]         mv;
      logic [rk4_smd_pkg::DIV_W-1:0]         qx;
      logic [rk4_smd_pkg::DIV_W-1:0]         qv;
      logic [rk4_smd_pkg::DIV_REM_W-1:0]     rx;
      logic [rk4_smd_pkg::DIV_REM_W-1:0]     rv;
      logic                                  sat;
   } pipe_type;

   // Configuration registers.
   logic signed [rk4_smd_pkg::DATA_W-1:0] stiff_ff;
   logic signed [rk4_smd_pkg::DATA_W-1:0] damp_ff;
   logic [rk4_smd_pkg::UREG_W-1:0]        inv_mass_ff;
   logic [rk4_smd_pkg::UREG_W-1:0]        step_ff;
   logic signed [rk4_smd_pkg::DATA_W-1:0] grav_ff [rk4_smd_pkg::GRAVITY_REGS];

   logic signed [rk4_smd_pkg::PROD_W-1:0] stiff_ext;
   logic signed [rk4_smd_pkg::PROD_W-1:0] damp_ext;
   logic signed [rk4_smd_pkg::PROD_W-1:0] inv_mass_ext;
   logic signed [rk4_smd_pkg::PROD_W-1:0] step_ext;

   // Pipeline.
   pipe_type st_ff  [NSTG];
   pipe_type st_in  [NSTG];
   pipe_type src    [NSTG];
   logic     vld_ff [NSTG];
   logic     vsrc   [NSTG];
   logic     adv    [NSTG+1];
   pipe_type head;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         stiff_ff    <= rk4_smd_pkg::STIFF_RESET;
         damp_ff     <= rk4_smd_pkg::DAMP_RESET;
         inv_mass_ff <= rk4_smd_pkg::IMASS_RESET;
         step_ff     <= rk4_smd_pkg::STEP_RESET;
         for (int i = 0; i < rk4_smd_pkg::GRAVITY_REGS; i++) begin
            grav_ff[i] <= rk4_smd_pkg::GRAV_RESET;
         end
      end else if (csr_valid) begin
         case (csr_index)
            rk4_smd_pkg::CSR_STIFFNESS: stiff_ff    <= csr_wdata;
            rk4_smd_pkg::CSR_DAMPING:   damp_ff     <= csr_wdata;
            rk4_smd_pkg::CSR_INV_MASS:  inv_mass_ff <= csr_wdata[rk4_smd_pkg::UREG_W-1:0];
            rk4_smd_pkg::CSR_STEP:      step_ff     <= csr_wdata[rk4_smd_pkg::UREG_W-1:0];
            rk4_smd_pkg::CSR_GRAV_X:    grav_ff[0]  <= csr_wdata;
            rk4_smd_pkg::CSR_GRAV_Y:    grav_ff[1]  <= csr_wdata;
            rk4_smd_pkg::CSR_GRAV_Z:    grav_ff[2]  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // The unsigned registers enter the signed multipliers with a zero sign bit.
   assign stiff_ext    = rk4_smd_pkg::PROD_W'(stiff_ff);
   assign damp_ext     = rk4_smd_pkg::PROD_W'(damp_ff);
   assign inv_mass_ext = rk4_smd_pkg::PROD_W'(signed'({1'b0, inv_mass_ff}));
   assign step_ext     = rk4_smd_pkg::PROD_W'(signed'({1'b0, step_ff}));

   // Incoming item: the first stage point is the item's own position and
   // velocity; an axis without a gravity register sees zero gravity.
   always_comb begin
      head    = '0;
      head.x  = req_position;
      head.v  = req_velocity;
      head.xs = req_position;
      head.vs = req_velocity;
      if (req_axis_index < rk4_smd_pkg::AXIS_W'(rk4_smd_pkg::GRAVITY_REGS) &&
          int'(req_axis_index) < rk4_smd_pkg::AXES) begin
         head.g = grav_ff[req_axis_index];
      end
   end

   // Flow control: a stage moves when it is empty or the next one moves.
   assign adv[NSTG] = rsp_ready;
   assign src[0]    = head;
   assign vsrc[0]   = req_valid;

   for (genvar i = 0; i < NSTG; i++) begin : g_ctl
      assign adv[i] = ~vld_ff[i] | adv[i+1];
      if (i > 0) begin : g_link
         assign src[i]  = st_ff[i-1];
         assign vsrc[i] = vld_ff[i-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (adv[i]) begin
            vld_ff[i] <= vsrc[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv[i]) begin
            st_ff[i] <= st_in[i];
         end
      end
   end

   assign req_ready = adv[0];

   // The four slope evaluations.
   for (genvar j = 0; j < RK_STAGES; j++) begin : g_rk
      localparam int B = j * STG_PER_RK;
      // The middle two slopes carry a weight of two in the final sum.
      localparam int WSH = (j == 1 || j == 2) ? 1 : 0;
      localparam logic [rk4_smd_pkg::SHIFT_W-1:0] USH = (j < 2) ? SHIFT_HALF : SHIFT_FULL;

      // Spring and damper products; the first evaluation also scales the force.
      always_comb begin
         st_in[B]    = src[B];
         st_in[B].pa = stiff_ext * rk4_smd_pkg::PROD_W'(src[B].xs);
         st_in[B].pb = damp_ext * rk4_smd_pkg::PROD_W'(src[B].vs);
         if (j == 0) begin
            st_in[B].pc = inv_mass_ext * rk4_smd_pkg::PROD_W'(req_external_force);
         end
      end

      // Negated spring and damper terms; force plus gravity once per item.
      always_comb begin
         logic signed [RW-1:0] rk;
         logic signed [RW-1:0] rc;
         logic signed [RW-1:0] rf;
         rk = RW'(rk4_smd_pkg::round_shift(src[B+1].pa, SHIFT_FULL));
         rc = RW'(rk4_smd_pkg::round_shift(src[B+1].pb, SHIFT_FULL));
         rf = RW'(rk4_smd_pkg::round_shift(src[B+1].pc, SHIFT_FULL));
         st_in[B+1]    = src[B+1];
         st_in[B+1].ns = -NSW'(rk) - NSW'(rc);
         if (j == 0) begin
            st_in[B+1].fg = FGW'(rf) + FGW'(src[B+1].g);
         end
      end

      // Acceleration, and the position slope joins the weighted sum.
      always_comb begin
         logic signed [AW-1:0]  acc;
         rk4_smd_pkg::clip_type cl;
         acc = AW'(src[B+2].ns) + AW'(src[B+2].fg);
         cl  = rk4_smd_pkg::clip32(rk4_smd_pkg::PROD_W'(acc));
         st_in[B+2]     = src[B+2];
         st_in[B+2].kv  = cl.val;
         st_in[B+2].sat = src[B+2].sat | cl.sat;
         st_in[B+2].sx  = src[B+2].sx + (rk4_smd_pkg::SUM_W'(src[B+2].vs) <<< WSH);
      end

      if (j < RK_STAGES - 1) begin : g_adv
         // Step-size products for the next stage point; the velocity slope joins its weighted sum.
         always_comb begin
            st_in[B+3]    = src[B+3];
            st_in[B+3].pa = step_ext * rk4_smd_pkg::PROD_W'(src[B+3].vs);
            st_in[B+3].pb = step_ext * rk4_smd_pkg::PROD_W'(src[B+3].kv);
            st_in[B+3].sv = src[B+3].sv + (rk4_smd_pkg::SUM_W'(src[B+3].kv) <<< WSH);
         end

         // Next stage point, at h/2 for the first two and h for the third.
         always_comb begin
            logic signed [RW-1:0]  dx;
            logic signed [RW-1:0]  dv;
            logic signed [UW-1:0]  ux;
            logic signed [UW-1:0]  uv;
            rk4_smd_pkg::clip_type cx;
            rk4_smd_pkg::clip_type cv;
            dx = RW'(rk4_smd_pkg::round_shift(src[B+4].pa, USH));
            dv = RW'(rk4_smd_pkg::round_shift(src[B+4].pb, USH));
            ux = UW'(src[B+4].x) + UW'(dx);
            uv = UW'(src[B+4].v) + UW'(dv);
            cx = rk4_smd_pkg::clip32(rk4_smd_pkg::PROD_W'(ux));
            cv = rk4_smd_pkg::clip32(rk4_smd_pkg::PROD_W'(uv));
            st_in[B+4]     = src[B+4];
            st_in[B+4].xs  = cx.val;
            st_in[B+4].vs  = cv.val;
            st_in[B+4].sat = src[B+4].sat | cx.sat | cv.sat;
         end
      end
   end

   // Close the weighted sums and bias them into positive dividends.
   always_comb begin
      logic signed [rk4_smd_pkg::DIV_W:0] tx;
      logic signed [rk4_smd_pkg::DIV_W:0] tv;
      tx = (rk4_smd_pkg::DIV_W + 1)'(src[STG_SUM].sx) + rk4_smd_pkg::DIV_BIAS;
      tv = (rk4_smd_pkg::DIV_W + 1)'(src[STG_SUM].sv) +
           (rk4_smd_pkg::DIV_W + 1)'(src[STG_SUM].kv) + rk4_smd_pkg::DIV_BIAS;
      st_in[STG_SUM]    = src[STG_SUM];
      st_in[STG_SUM].mx = tx[rk4_smd_pkg::DIV_W-1:0];
      st_in[STG_SUM].mv = tv[rk4_smd_pkg::DIV_W-1:0];
   end

   // Long division by six, most significant digits first. The bias adds
   // exactly 2^32 to the quotient, which drops out of its low 32 bits.
   for (genvar d = 0; d < DIV_STAGES; d++) begin : g_div
      localparam int S = STG_DIV + d;

      always_comb begin
         logic [rk4_smd_pkg::DIV_REM_W-1:0] rx;
         logic [rk4_smd_pkg::DIV_REM_W-1:0] rv;
         rk4_smd_pkg::div_step_type         ds_x;
         rk4_smd_pkg::div_step_type         ds_v;
         st_in[S] = src[S];
         rx = (d == 0) ? '0 : src[S].rx;
         rv = (d == 0) ? '0 : src[S].rv;
         for (int t = 0; t < DIV_PER_STG; t++) begin
            ds_x = rk4_smd_pkg::div6_step(rx, src[S].mx[rk4_smd_pkg::DIV_W - 1 -
                   (d * DIV_PER_STG + t) * rk4_smd_pkg::DIV_CHUNK -: rk4_smd_pkg::DIV_CHUNK]);
            ds_v = rk4_smd_pkg::div6_step(rv, src[S].mv[rk4_smd_pkg::DIV_W - 1 -
                   (d * DIV_PER_STG + t) * rk4_smd_pkg::DIV_CHUNK -: rk4_smd_pkg::DIV_CHUNK]);
            st_in[S].qx[rk4_smd_pkg::DIV_W - 1 - (d * DIV_PER_STG + t) *
                        rk4_smd_pkg::DIV_CHUNK -: rk4_smd_pkg::DIV_CHUNK] = ds_x.q;
            st_in[S].qv[rk4_smd_pkg::DIV_W - 1 - (d * DIV_PER_STG + t) *
                        rk4_smd_pkg::DIV_CHUNK -: rk4_smd_pkg::DIV_CHUNK] = ds_v.q;
            rx = ds_x.r;
            rv = ds_v.r;
         end
         st_in[S].rx = rx;
         st_in[S].rv = rv;
      end
   end

   // Final step-size products on the averaged slopes.
   always_comb begin
      st_in[STG_HMUL]    = src[STG_HMUL];
      st_in[STG_HMUL].pa = step_ext * rk4_smd_pkg::PROD_W'(
                           signed'(src[STG_HMUL].qx[rk4_smd_pkg::DATA_W-1:0]));
      st_in[STG_HMUL].pb = step_ext * rk4_smd_pkg::PROD_W'(
                           signed'(src[STG_HMUL].qv[rk4_smd_pkg::DATA_W-1:0]));
   end

   // Result: next position and velocity, loaded into the output register.
   always_comb begin
      logic signed [RW-1:0]  dx;
      logic signed [RW-1:0]  dv;
      logic signed [UW-1:0]  ux;
      logic signed [UW-1:0]  uv;
      rk4_smd_pkg::clip_type cx;
      rk4_smd_pkg::clip_type cv;
      dx = RW'(rk4_smd_pkg::round_shift(src[STG_OUT].pa, SHIFT_FULL));
      dv = RW'(rk4_smd_pkg::round_shift(src[STG_OUT].pb, SHIFT_FULL));
      ux = UW'(src[STG_OUT].x) + UW'(dx);
      uv = UW'(src[STG_OUT].v) + UW'(dv);
      cx = rk4_smd_pkg::clip32(rk4_smd_pkg::PROD_W'(ux));
      cv = rk4_smd_pkg::clip32(rk4_smd_pkg::PROD_W'(uv));
      st_in[STG_OUT]     = src[STG_OUT];
      st_in[STG_OUT].xs  = cx.val;
      st_in[STG_OUT].vs  = cv.val;
      st_in[STG_OUT].sat = src[STG_OUT].sat | cx.sat | cv.sat;
   end

   assign rsp_valid         = vld_ff[STG_OUT];
   assign rsp_next_position = st_ff[STG_OUT].xs;
   assign rsp_next_velocity = st_ff[STG_OUT].vs;
   assign rsp_saturated     = st_ff[STG_OUT].sat;

endmodule

@@ design/rk4_smd_checker.sv @@
// ----------------------------------------------------------------------------
// RK4 spring-mass-damper step: port checker
// Watches the ports of the step block and flags broken flow control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "rk4_spring_mass_damper_step_top_defines.svh"

module rk4_smd_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic [rk4_smd_pkg::AXIS_W-1:0]        req_axis_index,
   input logic signed [rk4_smd_pkg::DATA_W-1:0] req_position,
   input logic signed [rk4_smd_pkg::DATA_W-1:0] req_velocity,
   input logic signed [rk4_smd_pkg::DATA_W-1:0] req_external_force,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic signed [rk4_smd_pkg::DATA_W-1:0] rsp_next_position,
   input logic signed [rk4_smd_pkg::DATA_W-1:0] rsp_next_velocity,
   input logic                                  rsp_saturated,
   input logic                                  csr_valid,
   input logic                                  csr_ready,
   input logic [rk4_smd_pkg::CSR_IDX_W-1:0]     csr_index,
   input logic [rk4_smd_pkg::DATA_W-1:0]        csr_wdata
);

   // Reset empties the whole pipeline, the output register included.
   `RK4_ASSERT_NEXT(a_empty_after_reset, clock, 1'b0, reset, !rsp_valid)

   // With the output register free or draining, every stage can move, so the
   // block must take a new item.
   `RK4_ASSERT_IMP(a_ready_when_drained, clock, reset, !rsp_valid || rsp_ready, req_ready)

   // A stalled result stays put.
   `RK4_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_next_position) && $stable(rsp_next_velocity) && $stable(rsp_saturated))

endmodule

bind rk4_spring_mass_damper_step_top rk4_smd_checker u_rk4_smd_checker (.*);
